### hw/rtl/hpsc_pkg.sv
package hpsc_pkg;

    // Parser position inside one header field.
    typedef enum logic [2:0] {
        PH_FIELD_START,
        PH_INDEX_CONT,
        PH_NAME_CONT,
        PH_LEN_START,
        PH_LEN_CONT,
        PH_STR_BODY
    } phase_t;

    // Result codes reported once per header block.
    typedef enum logic [1:0] {
        OUT_FOUND     = 2'd0,
        OUT_NOT_FOUND = 2'd1,
        OUT_MALFORMED = 2'd2
    } outcome_t;

    // One incoming word: a header block byte and its end-of-block mark.
    typedef struct packed {
        logic [7:0] block_byte;
        logic       block_end;
    } blk_word_t;

    // One result word.
    typedef struct packed {
        logic signed [15:0] status_code;
        outcome_t           outcome;
    } res_word_t;

    // Prefix limits of the HPACK integer encoding.
    localparam logic [6:0] PREFIX7_MAX = 7'h7F;
    localparam logic [3:0] PREFIX4_MAX = 4'hF;

    // Static table entry of the status pseudo-header.
    localparam logic [31:0] STATUS_INDEX = 32'd8;
    localparam logic [3:0]  STATUS_INDEX4 = 4'd8;

    // Highest continuation step; shift is 7 * step, so step four is shift 28.
    localparam logic [2:0] LAST_STEP = 3'd4;

    // Status value implied by the indexed status entry.
    localparam logic signed [15:0] INDEXED_STATUS = 16'sd200;

    // Bias of three ASCII zero digits weighted 100, 10 and 1 (48 * 111).
    localparam logic [15:0] DIGIT_BIAS = 16'd5328;

    // A status string is exactly three bytes long.
    localparam logic [31:0] STATUS_LEN = 32'd3;

endpackage

### hw/rtl/hpack_status_scanner.sv
// Scans HPACK header blocks for the status field and returns one result word per block:
// found with the status value, not found, or malformed. It takes one block byte per clock
// cycle while the result side does not stall; a word goes through an input register and
// then the combinational parser step into a result register, which holds the result of
// the byte that decides it. After a decision the rest of the block is read and dropped
// without further results; the word marked as block end readies the next block.
module hpack_status_scanner
    import hpsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      blk_valid,
    output logic      blk_stall,
    input  blk_word_t blk_word,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res_word
);

    // Input register.
    logic      in_valid_reg;
    logic      in_valid_next;
    blk_word_t in_word_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [31:0] accum_reg, accum_next;
    logic [2:0]  step_reg, step_next;
    logic        name8_reg, name8_next;
    logic [31:0] remain_reg, remain_next;
    logic        len3_reg, len3_next;
    logic [1:0]  pos_reg, pos_next;
    logic        huff_reg, huff_next;
    logic [7:0]  dig0_reg, dig0_next;
    logic [7:0]  dig1_reg, dig1_next;
    logic        decided_reg, decided_next;

    // Result register.
    logic      res_valid_reg;
    logic      res_valid_next;
    res_word_t res_word_reg;

    logic        proc_fire;
    logic        res_load;
    logic        verdict_valid;
    res_word_t   verdict;
    logic [7:0]  b;
    logic        blk_last;
    logic [31:0] shifted;
    logic [31:0] int_sum;
    logic        int_done;
    logic        int_ovf;
    logic [15:0] digit_sum;

    // The parser steps whenever a byte waits in the input register and the result register can take a word.
    assign proc_fire = in_valid_reg && (!res_valid_reg || !res_stall);
    assign res_load  = proc_fire && verdict_valid;
    assign blk_stall = in_valid_reg && !proc_fire;
    assign b         = in_word_reg.block_byte;
    assign blk_last  = in_word_reg.block_end;

    // Continuation byte of a prefixed integer, placed at 7 bits per step.
    always_comb
    begin
        case (step_reg)
            3'd0:    shifted = {25'd0, b[6:0]};
            3'd1:    shifted = {18'd0, b[6:0], 7'd0};
            3'd2:    shifted = {11'd0, b[6:0], 14'd0};
            3'd3:    shifted = {4'd0, b[6:0], 21'd0};
            default: shifted = {b[3:0], 28'd0};
        endcase
    end

    assign int_sum  = accum_reg + shifted;
    assign int_done = !b[7];
    assign int_ovf  = b[7] && (step_reg == LAST_STEP);

    // Status from three digit bytes, the current byte being the last one.
    assign digit_sum = 16'(dig0_reg) * 16'd100 + 16'(dig1_reg) * 16'd10 + 16'(b) - DIGIT_BIAS;

    // Input register handshake.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (blk_valid && !blk_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Parser step for the byte in the input register.
    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        step_next     = step_reg;
        name8_next    = name8_reg;
        remain_next   = remain_reg;
        len3_next     = len3_reg;
        pos_next      = pos_reg;
        huff_next     = huff_reg;
        dig0_next     = dig0_reg;
        dig1_next     = dig1_reg;
        decided_next  = decided_reg;
        verdict_valid = 1'b0;
        verdict       = '{status_code: 16'sd0, outcome: OUT_NOT_FOUND};

        if (proc_fire && !decided_reg)
        begin
            case (phase_reg)
                PH_FIELD_START:
                begin
                    if (b[7])
                    begin
                        // Indexed field.
                        if (b[6:0] != PREFIX7_MAX)
                        begin
                            if ({25'd0, b[6:0]} == STATUS_INDEX)
                            begin
                                verdict_valid = 1'b1;
                                verdict = '{status_code: INDEXED_STATUS, outcome: OUT_FOUND};
                            end
                        end
                        else
                        begin
                            accum_next = {25'd0, PREFIX7_MAX};
                            step_next  = 3'd0;
                            phase_next = PH_INDEX_CONT;
                        end
                    end
                    else if (b[6:4] == 3'd0)
                    begin
                        // Literal without indexing, name by index.
                        if (b[3:0] != PREFIX4_MAX)
                        begin
                            name8_next = (b[3:0] == STATUS_INDEX4);
                            phase_next = PH_LEN_START;
                        end
                        else
                        begin
                            accum_next = {28'd0, PREFIX4_MAX};
                            step_next  = 3'd0;
                            phase_next = PH_NAME_CONT;
                        end
                    end
                    else
                    begin
                        verdict_valid = 1'b1;
                        verdict = '{status_code: 16'sd0, outcome: OUT_MALFORMED};
                    end
                end
                PH_INDEX_CONT:
                begin
                    accum_next = int_sum;
                    step_next  = step_reg + 3'd1;
                    if (int_done)
                    begin
                        phase_next = PH_FIELD_START;
                        if (int_sum == STATUS_INDEX)
                        begin
                            verdict_valid = 1'b1;
                            verdict = '{status_code: INDEXED_STATUS, outcome: OUT_FOUND};
                        end
                    end
                    else if (int_ovf)
                    begin
                        verdict_valid = 1'b1;
                        verdict = '{status_code: 16'sd0, outcome: OUT_MALFORMED};
                    end
                end
                PH_NAME_CONT:
                begin
                    accum_next = int_sum;
                    step_next  = step_reg + 3'd1;
                    if (int_done)
                    begin
                        name8_next = (int_sum == STATUS_INDEX);
                        phase_next = PH_LEN_START;
                    end
                    else if (int_ovf)
                    begin
                        verdict_valid = 1'b1;
                        verdict = '{status_code: 16'sd0, outcome: OUT_MALFORMED};
                    end
                end
                PH_LEN_START:
                begin
                    huff_next = b[7];
                    if (b[6:0] != PREFIX7_MAX)
                    begin
                        // Short length; an empty string ends the field at once.
                        len3_next   = ({25'd0, b[6:0]} == STATUS_LEN);
                        remain_next = {25'd0, b[6:0]};
                        pos_next    = 2'd0;
                        phase_next  = (b[6:0] == 7'd0) ? PH_FIELD_START : PH_STR_BODY;
                    end
                    else
                    begin
                        accum_next = {25'd0, PREFIX7_MAX};
                        step_next  = 3'd0;
                        phase_next = PH_LEN_CONT;
                    end
                end
                PH_LEN_CONT:
                begin
                    accum_next = int_sum;
                    step_next  = step_reg + 3'd1;
                    if (int_done)
                    begin
                        len3_next   = (int_sum == STATUS_LEN);
                        remain_next = int_sum;
                        pos_next    = 2'd0;
                        phase_next  = (int_sum == 32'd0) ? PH_FIELD_START : PH_STR_BODY;
                    end
                    else if (int_ovf)
                    begin
                        verdict_valid = 1'b1;
                        verdict = '{status_code: 16'sd0, outcome: OUT_MALFORMED};
                    end
                end
                PH_STR_BODY:
                begin
                    // Keep the first two bytes; the third is taken straight from the input.
                    if (pos_reg == 2'd0)
                    begin
                        dig0_next = b;
                    end
                    if (pos_reg == 2'd1)
                    begin
                        dig1_next = b;
                    end
                    if (pos_reg != 2'd3)
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_FIELD_START;
                        if (!huff_reg && name8_reg && len3_reg)
                        begin
                            verdict_valid = 1'b1;
                            verdict = '{status_code: $signed(digit_sum), outcome: OUT_FOUND};
                        end
                    end
                end
                default:
                begin
                    phase_next    = PH_FIELD_START;
                    verdict_valid = 1'b1;
                    verdict = '{status_code: 16'sd0, outcome: OUT_MALFORMED};
                end
            endcase

            // Block ends without a decision.
            if (!verdict_valid && blk_last)
            begin
                verdict_valid = 1'b1;
                verdict.status_code = 16'sd0;
                verdict.outcome = (phase_next == PH_FIELD_START) ? OUT_NOT_FOUND
                                                                 : OUT_MALFORMED;
            end
        end

        // Block end readies the next block; a decision mutes the rest of this one.
        if (proc_fire)
        begin
            if (blk_last)
            begin
                phase_next   = PH_FIELD_START;
                decided_next = 1'b0;
            end
            else if (verdict_valid)
            begin
                decided_next = 1'b1;
            end
        end
    end

    // Result register handshake.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_FIELD_START;
            decided_reg   <= 1'b0;
            step_reg      <= 3'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
            decided_reg   <= decided_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (blk_valid && !blk_stall)
        begin
            in_word_reg <= blk_word;
        end
        if (res_load)
        begin
            res_word_reg <= verdict;
        end
        accum_reg  <= accum_next;
        name8_reg  <= name8_next;
        remain_reg <= remain_next;
        len3_reg   <= len3_next;
        pos_reg    <= pos_next;
        huff_reg   <= huff_next;
        dig0_reg   <= dig0_next;
        dig1_reg   <= dig1_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // A result other than found carries a zero status.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.outcome != OUT_FOUND |-> res_word.status_code == 16'sd0)
        else $error("non-found result carries a status value");

    // Once a block is decided, no further result comes from it.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && decided_reg |-> !res_load)
        else $error("second result within one header block");

    // The end of a block always returns the parser to the start of a field.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && blk_last |=> !decided_reg && phase_reg == PH_FIELD_START)
        else $error("parser not cleared after block end");

    // An undecided block end always produces exactly one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && blk_last && !decided_reg |-> res_load)
        else $error("block ended without a result");

    // The continuation step never passes the last allowed step while parsing.
    assert property (@(posedge clk) disable iff (!rst_n)
        !decided_reg && (phase_reg == PH_INDEX_CONT || phase_reg == PH_NAME_CONT
                         || phase_reg == PH_LEN_CONT) |-> step_reg <= LAST_STEP)
        else $error("integer continuation step out of range");

endmodule
